[src/hdlc_dfr_pkg.sv]
`default_nettype none

package hdlc_dfr_pkg;

  // largest number of stored bytes in one frame
  localparam int unsigned BUF_DEPTH = 256;
  localparam int unsigned CNT_W     = $clog2(BUF_DEPTH + 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0] FLAG_RESET = 8'h7E;
  localparam logic [7:0] ESC_RESET  = 8'h7D;
  localparam logic [7:0] MASK_RESET = 8'h20;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG_CODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_MASK = 2'd2;

  localparam logic [1:0] STAT_NONE     = 2'd0;
  localparam logic [1:0] STAT_GOOD     = 2'd1;
  localparam logic [1:0] STAT_BAD_CRC  = 2'd2;
  localparam logic [1:0] STAT_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [1:0] frame_status;
    logic [7:0] payload_length;
    logic       data_valid;
    logic [7:0] data_value;
    logic [7:0] data_position;
  } res_t;

  // crc-16/ccitt-false, msb first, one byte
  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[src/hdlc_byte_deframer_crc_check_unit.sv]
// hdlc byte deframer with crc-16/ccitt-false check
//
// input channel: in_valid / in_stall / in_rx_byte, one raw line byte per item.
// result channel: out_valid / out_stall and the result fields; every input
// item gives exactly one result item, in order.
// config channel: cfg_valid / cfg_ready / cfg_index / cfg_data; cfg_ready is
// always high. index 0 flag code, 1 escape code, 2 escape mask, 3 ignored.
// write config only while no item is in flight.
// each result is registered: in the result register, or in the skid register.
// throughput: one item per cycle while in_stall is low; the whole de-stuffing
// step and the 8-bit crc update sit between the input handshake and the result
// register. when the receiver stalls, the result register holds and one more
// result goes into a skid register; in_stall rises only while that skid is full.
// reset: codes return to 0x7e / 0x7d / 0x20, the receiver goes idle with
// crc 0xffff and empty channels; nothing is accepted during reset.
`default_nettype none

module hdlc_byte_deframer_crc_check_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [7:0]                         in_rx_byte,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [1:0]                              out_frame_status,
  output logic [7:0]                              out_payload_length,
  output logic                                    out_data_valid,
  output logic [7:0]                              out_data_value,
  output logic [7:0]                              out_data_position,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [hdlc_dfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                         cfg_data
);
  import hdlc_dfr_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_IN_FRAME,
    MODE_ESCAPED
  } mode_t;

  logic [7:0] flag_r, esc_r, mask_r;

  mode_t            mode_r, mode_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       older_r, older_nxt;
  logic [7:0]       newer_r, newer_nxt;

  res_t res;
  res_t out_r, skid_r;
  logic out_v_r, skid_v_r;

  logic               acc_in, out_take, store;
  logic [7:0]         db;
  logic [CNT_W+7:0]   cnt_ext, len_ext;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_v_r;
  assign acc_in    = in_valid && !skid_v_r;
  assign out_take  = out_v_r && !out_stall;

  assign cnt_ext = {8'd0, cnt_r};
  assign len_ext = cnt_ext - (CNT_W + 8)'(2);

  always_comb begin
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    older_nxt = older_r;
    newer_nxt = newer_r;
    res       = '0;
    store     = 1'b0;
    db        = in_rx_byte;
    if (in_rx_byte == flag_r) begin
      if (mode_r == MODE_IN_FRAME && cnt_r >= CNT_W'(2)) begin
        if ({older_r, newer_r} == crc_r) begin
          res.frame_status   = STAT_GOOD;
          res.payload_length = (len_ext > (CNT_W + 8)'(255)) ? 8'hFF : len_ext[7:0];
        end else begin
          res.frame_status = STAT_BAD_CRC;
        end
        mode_nxt = MODE_IDLE;
      end else begin
        mode_nxt = MODE_IN_FRAME;
      end
      cnt_nxt   = '0;
      crc_nxt   = CRC_INIT;
      older_nxt = '0;
      newer_nxt = '0;
    end else if (mode_r != MODE_IDLE) begin
      store = 1'b1;
      if (mode_r == MODE_ESCAPED) begin
        db       = in_rx_byte ^ mask_r;
        mode_nxt = MODE_IN_FRAME;
      end else if (in_rx_byte == esc_r) begin
        mode_nxt = MODE_ESCAPED;
        store    = 1'b0;
      end
      if (store) begin
        if (cnt_r == CNT_W'(BUF_DEPTH)) begin
          res.frame_status = STAT_OVERFLOW;
          mode_nxt  = MODE_IDLE;
          cnt_nxt   = '0;
          crc_nxt   = CRC_INIT;
          older_nxt = '0;
          newer_nxt = '0;
        end else begin
          // the two newest bytes stay out of the crc until a later byte pushes them
          if (cnt_r >= CNT_W'(2)) begin
            crc_nxt = crc_add_byte(crc_r, older_r);
          end
          older_nxt         = newer_r;
          newer_nxt         = db;
          res.data_valid    = 1'b1;
          res.data_value    = db;
          res.data_position = cnt_ext[7:0];
          cnt_nxt           = cnt_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r   <= FLAG_RESET;
      esc_r    <= ESC_RESET;
      mask_r   <= MASK_RESET;
      mode_r   <= MODE_IDLE;
      cnt_r    <= '0;
      crc_r    <= CRC_INIT;
      older_r  <= '0;
      newer_r  <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FLAG_CODE:   flag_r <= cfg_data;
          CFG_ESCAPE_CODE: esc_r  <= cfg_data;
          CFG_ESCAPE_MASK: mask_r <= cfg_data;
          default: ;
        endcase
      end
      if (acc_in) begin
        mode_r  <= mode_nxt;
        cnt_r   <= cnt_nxt;
        crc_r   <= crc_nxt;
        older_r <= older_nxt;
        newer_r <= newer_nxt;
      end
      if (skid_v_r) begin
        if (out_take) begin
          out_r    <= skid_r;
          skid_v_r <= 1'b0;
        end
      end else if (acc_in) begin
        if (!out_v_r || out_take) begin
          out_r   <= res;
          out_v_r <= 1'b1;
        end else begin
          skid_r   <= res;
          skid_v_r <= 1'b1;
        end
      end else if (out_take) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_v_r;
  assign out_frame_status   = out_r.frame_status;
  assign out_payload_length = out_r.payload_length;
  assign out_data_valid     = out_r.data_valid;
  assign out_data_value     = out_r.data_value;
  assign out_data_position  = out_r.data_position;

endmodule

`default_nettype wire

[src/hdlc_dfr_checker.sv]
`default_nettype none

module hdlc_dfr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_frame_status,
  input wire logic [7:0] out_payload_length,
  input wire logic       out_data_valid,
  input wire logic [7:0] out_data_value,
  input wire logic [7:0] out_data_position
);
  import hdlc_dfr_pkg::*;

  // a stored byte and a frame report never come with the same item
  a_data_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data_valid |-> out_frame_status == STAT_NONE)
    else $error("stored byte reported together with a frame status");

  // length is only given for a good frame
  a_len_only_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status != STAT_GOOD |-> out_payload_length == 8'd0)
    else $error("payload length without a good frame");

  // byte fields are zero when no byte was stored
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data_valid |-> out_data_value == 8'd0 && out_data_position == 8'd0)
    else $error("data fields set without a stored byte");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_status)
      && $stable(out_payload_length) && $stable(out_data_valid)
      && $stable(out_data_value) && $stable(out_data_position))
    else $error("stalled result changed");

endmodule

bind hdlc_byte_deframer_crc_check_unit hdlc_dfr_checker u_hdlc_dfr_checker (.*);

`default_nettype wire
